>>> hdl/bse_pkg.sv
package bse_pkg;

  // Storage geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Fixed field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;

  // Capacity register reset value
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // Request kinds; the fourth code is unused and ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2
  } req_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_e;

endpackage

>>> hdl/bse_if.sv
// Request channel
interface bse_req_if;
  logic                               valid;
  logic                               ready;
  logic [bse_pkg::REQ_W-1:0]          req_type;
  logic signed [bse_pkg::WORD_W-1:0]  push_value;
  logic [bse_pkg::CNT_W-1:0]          peek_position;

  modport source (output valid, req_type, push_value, peek_position, input ready);
  modport sink   (input valid, req_type, push_value, peek_position, output ready);
endinterface

// Result channel
interface bse_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [bse_pkg::WORD_W-1:0]  read_value;
  logic [bse_pkg::STAT_W-1:0]         status;
  logic [bse_pkg::CNT_W-1:0]          occupancy;

  modport source (output valid, read_value, status, occupancy, input ready);
  modport sink   (input valid, read_value, status, occupancy, output ready);
endinterface

// Capacity write channel
interface bse_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bse_pkg::CNT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/bse_ram.sv
module bse_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [bse_pkg::AW-1:0]     waddr_i,
  input  logic [bse_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [bse_pkg::AW-1:0]     raddr_i,
  output logic [bse_pkg::WORD_W-1:0] rdata_o
);

  logic [bse_pkg::WORD_W-1:0] mem_q [bse_pkg::DEPTH];
  logic [bse_pkg::WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bounded_stack_engine_unit.sv
// Channel   Direction  Payload
// req_i     in         req_type, push_value, peek_position
// rsp_o     out        read_value, status, occupancy
// cfg_i     in         data (capacity)
//
// Push, any error and the unused request kind go straight into the result register.
// Pop and peek that hit an entry pass through the RAM read port and the S_READ state first.
// A new item is taken when idle and the result register is free or being drained.
// Reset empties the stack and sets capacity to DEPTH; entries are not cleared.
// A stalled result holds in its register; cfg_i is always ready.
module bounded_stack_engine_unit (
  input  logic clk_i,
  input  logic rst_ni,
  bse_req_if.sink   req_i,
  bse_rsp_if.source rsp_o,
  bse_cfg_if.sink   cfg_i
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                      state_q;
  logic [bse_pkg::CNT_W-1:0]   cap_q;
  logic [bse_pkg::CNT_W-1:0]   fill_q, fill_d;
  logic                        rsp_valid_q;
  logic [bse_pkg::WORD_W-1:0]  rsp_value_q;
  bse_pkg::status_e            rsp_status_q, status_d;
  logic [bse_pkg::CNT_W-1:0]   rsp_occ_q;

  logic                        accept;
  logic                        need_read;
  logic                        mem_we;
  logic [bse_pkg::AW-1:0]      raddr;
  logic [bse_pkg::CNT_W-1:0]   eff_cap;
  logic [bse_pkg::CNT_W-1:0]   peek_idx;
  logic [bse_pkg::WORD_W-1:0]  rdata;

  // Capacity register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bse_pkg::CAP_RESET;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.data;
    end
  end

  // Clamp capacity into 1..DEPTH
  always_comb begin
    eff_cap = cap_q;
    if (cap_q == '0) begin
      eff_cap = bse_pkg::CNT_W'(1);
    end else if (cap_q > bse_pkg::CNT_W'(bse_pkg::DEPTH)) begin
      eff_cap = bse_pkg::CNT_W'(bse_pkg::DEPTH);
    end
  end

  // Take an item when idle and the result slot frees up
  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Decode the request against the fill count
  always_comb begin
    fill_d    = fill_q;
    status_d  = bse_pkg::ST_OK;
    need_read = 1'b0;
    mem_we    = 1'b0;
    raddr     = fill_q[bse_pkg::AW-1:0];
    peek_idx  = fill_q - req_i.peek_position;
    case (req_i.req_type)
      bse_pkg::REQ_PUSH: begin
        if (fill_q >= eff_cap) begin
          status_d = bse_pkg::ST_OVERFLOW;
        end else begin
          mem_we = accept;
          fill_d = fill_q + bse_pkg::CNT_W'(1);
        end
      end
      bse_pkg::REQ_POP: begin
        if (fill_q == '0) begin
          status_d = bse_pkg::ST_UNDERFLOW;
        end else begin
          need_read = 1'b1;
          fill_d    = fill_q - bse_pkg::CNT_W'(1);
          raddr     = fill_d[bse_pkg::AW-1:0];
        end
      end
      bse_pkg::REQ_PEEK: begin
        if (req_i.peek_position == '0 || req_i.peek_position > fill_q) begin
          status_d = bse_pkg::ST_BADPOS;
        end else begin
          need_read = 1'b1;
          raddr     = peek_idx[bse_pkg::AW-1:0];
        end
      end
      default: begin
        status_d = bse_pkg::ST_OK;
      end
    endcase
  end

  // Stack storage
  bse_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[bse_pkg::AW-1:0]),
    .wdata_i (req_i.push_value),
    .re_i    (accept && need_read),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer, fill count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_value_q  <= '0;
      rsp_status_q <= bse_pkg::ST_OK;
      rsp_occ_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fill_q <= fill_d;
            if (need_read) begin
              // Old result drains at this edge; the new one follows the read
              state_q     <= S_READ;
              rsp_valid_q <= 1'b0;
            end else begin
              rsp_valid_q  <= 1'b1;
              rsp_value_q  <= '0;
              rsp_status_q <= status_d;
              rsp_occ_q    <= fill_d;
            end
          end else if (rsp_valid_q && rsp_o.ready) begin
            rsp_valid_q <= 1'b0;
          end
        end
        S_READ: begin
          state_q      <= S_IDLE;
          rsp_valid_q  <= 1'b1;
          rsp_value_q  <= rdata;
          rsp_status_q <= bse_pkg::ST_OK;
          rsp_occ_q    <= fill_q;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rsp_value_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.occupancy  = rsp_occ_q;

`ifndef SYNTH
  // Fill count never exceeds the storage depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= bse_pkg::CNT_W'(bse_pkg::DEPTH))
    else $error("fill count above depth");

  // A read cycle always produces a result next
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> rsp_valid_q && state_q == S_IDLE)
    else $error("read cycle lost its result");

  // A successful push grows the stack by one
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mem_we |=> fill_q == $past(fill_q) + bse_pkg::CNT_W'(1))
    else $error("push did not advance fill count");

  // No overflow result while the stack is below capacity
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d == bse_pkg::ST_OVERFLOW |-> fill_q >= eff_cap)
    else $error("overflow below capacity");
`endif

endmodule
